// File: src/cut_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cut_pkg: shared types, constants and functions for the uptime calculator
// Holds the field widths, register map, calendar tables and the stage
// payload types that pass between the pipeline modules.
// ---------------------------------------------------------------------------
package cut_pkg;

	localparam int YEAR_W  = 7;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int UPD_W   = 16;
	localparam int DAYS_W  = 16;
	localparam int TOD_W   = 17;
	localparam int SDAYS_W = 18;
	localparam int STOD_W  = 18;
	localparam int REM_W   = 12;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [2:0] REG_BOOT_YEAR    = 3'd0;
	localparam logic [2:0] REG_BOOT_MONTH   = 3'd1;
	localparam logic [2:0] REG_BOOT_DAY     = 3'd2;
	localparam logic [2:0] REG_BOOT_HOURS   = 3'd3;
	localparam logic [2:0] REG_BOOT_MINUTES = 3'd4;
	localparam logic [2:0] REG_BOOT_SECS    = 3'd5;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

	// Reciprocals for exact floor division over the value ranges used.
	localparam logic [15:0] HOUR_RECIP = 16'd37283;
	localparam int          HOUR_SHIFT = 27;
	localparam logic [12:0] MIN_RECIP  = 13'd4370;
	localparam int          MIN_SHIFT  = 18;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   secs;
	} cut_stamp_t;

	typedef struct packed {
		logic [DAYS_W-1:0] now_days;
		logic [DAYS_W-1:0] boot_days;
		logic [TOD_W-1:0]  now_tod;
		logic [TOD_W-1:0]  boot_tod;
	} cut_conv_t;

	typedef struct packed {
		logic signed [SDAYS_W-1:0] days;
		logic [TOD_W-1:0]          tod;
	} cut_norm_t;

	typedef struct packed {
		logic [UPD_W-1:0]  days;
		logic [HOUR_W-1:0] hours;
		logic [MIN_W-1:0]  minutes;
		logic [SEC_W-1:0]  seconds;
		logic              went_back;
	} cut_result_t;

	function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAYS_W-1:0] days_since_base(input cut_stamp_t t);
		logic [DAYS_W-1:0]  year_days;
		logic [7:0]         y_plus3;
		logic [5:0]         q4;
		logic [5:0]         c100;
		logic [5:0]         c400;
		logic [5:0]         leaps;
		logic [MONTH_W-1:0] mc;
		logic               leap;
		logic [DAY_W-1:0]   dd;
		year_days = DAYS_W'(t.year) * 16'd365;
		y_plus3 = 8'(t.year) + 8'd3;
		q4 = 6'(y_plus3 >> 2);
		if (t.year == '0) begin
			c100 = 6'd0;
		end else if (t.year > 7'd100) begin
			c100 = 6'd2;
		end else begin
			c100 = 6'd1;
		end
		c400 = (t.year != '0) ? 6'd1 : 6'd0;
		leaps = q4 - c100 + c400;
		if (t.month == '0) begin
			mc = 4'd1;
		end else if (t.month > 4'd12) begin
			mc = 4'd12;
		end else begin
			mc = t.month;
		end
		leap = (t.year[1:0] == 2'b00) && (t.year != 7'd100);
		dd = (t.day == '0) ? '0 : t.day - 5'd1;
		return year_days + DAYS_W'(leaps) + DAYS_W'(month_offset(mc))
			+ DAYS_W'(leap && (mc > 4'd2)) + DAYS_W'(dd);
	endfunction

	function automatic logic [TOD_W-1:0] time_of_day(input cut_stamp_t t);
		return TOD_W'(t.hours) * TOD_W'(SECS_PER_HOUR)
			+ TOD_W'(t.minutes) * TOD_W'(SECS_PER_MIN) + TOD_W'(t.secs);
	endfunction

endpackage

// File: src/cut_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cut_in_if / cut_out_if: item channels of the uptime calculator
// Valid/ready channels carrying the current calendar time and the uptime.
// ---------------------------------------------------------------------------
interface cut_in_if;
	import cut_pkg::*;

	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  now_year;
	logic [MONTH_W-1:0] now_month;
	logic [DAY_W-1:0]   now_day;
	logic [HOUR_W-1:0]  now_hours;
	logic [MIN_W-1:0]   now_minutes;
	logic [SEC_W-1:0]   now_secs;

	modport source (
		output valid, now_year, now_month, now_day, now_hours, now_minutes, now_secs,
		input  ready
	);
	modport sink (
		input  valid, now_year, now_month, now_day, now_hours, now_minutes, now_secs,
		output ready
	);
endinterface

interface cut_out_if;
	import cut_pkg::*;

	logic              valid;
	logic              ready;
	logic [UPD_W-1:0]  up_days;
	logic [HOUR_W-1:0] up_hours;
	logic [MIN_W-1:0]  up_minutes;
	logic [SEC_W-1:0]  up_seconds;
	logic              clock_went_back;

	modport source (
		output valid, up_days, up_hours, up_minutes, up_seconds, clock_went_back,
		input  ready
	);
	modport sink (
		input  valid, up_days, up_hours, up_minutes, up_seconds, clock_went_back,
		output ready
	);
endinterface

// File: src/calendar_uptime_calculator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// calendar_uptime_calculator: uptime from calendar time and boot time
// Converts the current time and the boot time to days and seconds since
// 2000 and reports the difference as days, hours, minutes and seconds.
// ---------------------------------------------------------------------------
//  Port   | Kind          | Carries
//  -------+---------------+-------------------------------------------
//  now    | valid/ready   | current year, month, day, hours, min, secs
//  up     | valid/ready   | uptime days, hours, min, secs, went-back flag
//  p*     | APB write/read| boot time registers
//
// One item is accepted per cycle while the output is not stalled. An item
// passes six pipeline registers, from the epoch stage and the difference
// stage through the three split stages to the output register.
// Reset clears the valid bits of all stages and loads the boot time of
// 1 Jan 2000 00:00:00. A stall on the output freezes only the full stages
// from the output back to the first empty one, so no item is lost or repeated.
// ---------------------------------------------------------------------------
module calendar_uptime_calculator (
	input  logic                       clk,
	input  logic                       arst_n,
	cut_in_if.sink                     now,
	cut_out_if.source                  up,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cut_pkg::APB_AW-1:0] paddr,
	input  logic [cut_pkg::APB_DW-1:0] pwdata,
	output logic [cut_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import cut_pkg::*;

	localparam int NSTG = 6;

	cut_stamp_t  boot;
	cut_stamp_t  now_t;
	cut_conv_t   conv_s1;
	cut_norm_t   norm_s2;
	cut_result_t res_s6;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	cut_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.boot    (boot)
	);

	assign now_t.year    = now.now_year;
	assign now_t.month   = now.now_month;
	assign now_t.day     = now.now_day;
	assign now_t.hours   = now.now_hours;
	assign now_t.minutes = now.now_minutes;
	assign now_t.secs    = now.now_secs;

	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || up.ready;
		for (int k = NSTG-2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= now.valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign now.ready = en[0];

	cut_epoch_stage u_epoch (
		.clk     (clk),
		.en      (en[0]),
		.now     (now_t),
		.boot    (boot),
		.conv_s1 (conv_s1)
	);

	cut_diff_stage u_diff (
		.clk     (clk),
		.en      (en[1]),
		.conv    (conv_s1),
		.norm_s2 (norm_s2)
	);

	cut_split_stage u_split (
		.clk    (clk),
		.en     (en[5:2]),
		.norm   (norm_s2),
		.res_s6 (res_s6)
	);

	assign up.valid           = vld_q[NSTG-1];
	assign up.up_days         = res_s6.days;
	assign up.up_hours        = res_s6.hours;
	assign up.up_minutes      = res_s6.minutes;
	assign up.up_seconds      = res_s6.seconds;
	assign up.clock_went_back = res_s6.went_back;

endmodule

// File: src/cut_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cut_cfg_regs: boot time register file
// APB-style write and read access to the six boot time registers.
// ---------------------------------------------------------------------------
module cut_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cut_pkg::APB_AW-1:0]  paddr,
	input  logic [cut_pkg::APB_DW-1:0]  pwdata,
	output logic [cut_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output cut_pkg::cut_stamp_t         boot
);
	import cut_pkg::*;

	cut_stamp_t boot_q;
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite && pready;
	assign boot   = boot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q.year    <= '0;
			boot_q.month   <= 4'd1;
			boot_q.day     <= 5'd1;
			boot_q.hours   <= '0;
			boot_q.minutes <= '0;
			boot_q.secs    <= '0;
		end else if (wr) begin
			case (idx)
				REG_BOOT_YEAR:    boot_q.year    <= pwdata[YEAR_W-1:0];
				REG_BOOT_MONTH:   boot_q.month   <= pwdata[MONTH_W-1:0];
				REG_BOOT_DAY:     boot_q.day     <= pwdata[DAY_W-1:0];
				REG_BOOT_HOURS:   boot_q.hours   <= pwdata[HOUR_W-1:0];
				REG_BOOT_MINUTES: boot_q.minutes <= pwdata[MIN_W-1:0];
				REG_BOOT_SECS:    boot_q.secs    <= pwdata[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BOOT_YEAR:    prdata = APB_DW'(boot_q.year);
			REG_BOOT_MONTH:   prdata = APB_DW'(boot_q.month);
			REG_BOOT_DAY:     prdata = APB_DW'(boot_q.day);
			REG_BOOT_HOURS:   prdata = APB_DW'(boot_q.hours);
			REG_BOOT_MINUTES: prdata = APB_DW'(boot_q.minutes);
			REG_BOOT_SECS:    prdata = APB_DW'(boot_q.secs);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: src/cut_epoch_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cut_epoch_stage: calendar to day count and time of day
// Converts the current and boot times to days since 2000 and seconds of day.
// ---------------------------------------------------------------------------
module cut_epoch_stage (
	input  logic                clk,
	input  logic                en,
	input  cut_pkg::cut_stamp_t now,
	input  cut_pkg::cut_stamp_t boot,
	output cut_pkg::cut_conv_t  conv_s1
);
	import cut_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			conv_s1.now_days  <= days_since_base(now);
			conv_s1.boot_days <= days_since_base(boot);
			conv_s1.now_tod   <= time_of_day(now);
			conv_s1.boot_tod  <= time_of_day(boot);
		end
	end

endmodule

// File: src/cut_diff_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cut_diff_stage: uptime difference with day borrow
// Subtracts the boot time from the current time and folds the seconds
// difference into the range of one day, moving the carry into the days.
// ---------------------------------------------------------------------------
module cut_diff_stage (
	input  logic               clk,
	input  logic               en,
	input  cut_pkg::cut_conv_t conv,
	output cut_pkg::cut_norm_t norm_s2
);
	import cut_pkg::*;

	logic signed [SDAYS_W-1:0] dd;
	logic signed [STOD_W-1:0]  dt;
	logic signed [STOD_W-1:0]  dt_p1;
	logic signed [STOD_W-1:0]  dt_p2;
	logic signed [STOD_W-1:0]  dt_m1;
	logic signed [STOD_W-1:0]  day_s;
	logic signed [STOD_W-1:0]  t_fix;
	logic signed [SDAYS_W-1:0] d_fix;

	assign dd    = $signed(SDAYS_W'(conv.now_days)) - $signed(SDAYS_W'(conv.boot_days));
	assign dt    = $signed(STOD_W'(conv.now_tod)) - $signed(STOD_W'(conv.boot_tod));
	assign day_s = $signed(STOD_W'(SECS_PER_DAY));
	assign dt_p1 = dt + day_s;
	assign dt_p2 = dt_p1 + day_s;
	assign dt_m1 = dt - day_s;

	always_comb begin
		if (dt < 0) begin
			if (dt_p1 < 0) begin
				t_fix = dt_p2;
				d_fix = dd - SDAYS_W'(2);
			end else begin
				t_fix = dt_p1;
				d_fix = dd - SDAYS_W'(1);
			end
		end else if (dt_m1 >= 0) begin
			t_fix = dt_m1;
			d_fix = dd + SDAYS_W'(1);
		end else begin
			t_fix = dt;
			d_fix = dd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s2.days <= d_fix;
			norm_s2.tod  <= t_fix[TOD_W-1:0];
		end
	end

endmodule

// File: src/cut_split_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cut_split_stage: seconds of day to hours, minutes and seconds
// Four register stages: hour quotient, hour remainder, minute quotient and
// the output register, which also zeroes the result when time went back.
// ---------------------------------------------------------------------------
module cut_split_stage (
	input  logic                 clk,
	input  logic [3:0]           en,
	input  cut_pkg::cut_norm_t   norm,
	output cut_pkg::cut_result_t res_s6
);
	import cut_pkg::*;

	logic [32:0]        hprod;
	logic [24:0]        mprod;
	logic [TOD_W-1:0]   hsub;
	logic [REM_W-1:0]   msub;

	logic [UPD_W-1:0]   days_s3, days_s4, days_s5;
	logic               back_s3, back_s4, back_s5;
	logic [TOD_W-1:0]   tod_s3;
	logic [HOUR_W-1:0]  hours_s3, hours_s4, hours_s5;
	logic [REM_W-1:0]   rem_s4, rem_s5;
	logic [MIN_W-1:0]   mins_s5;

	assign hprod = 33'(norm.tod) * 33'(HOUR_RECIP);
	assign hsub  = tod_s3 - TOD_W'(hours_s3) * TOD_W'(SECS_PER_HOUR);
	assign mprod = 25'(rem_s4) * 25'(MIN_RECIP);
	assign msub  = rem_s5 - REM_W'(mins_s5) * REM_W'(SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			days_s3  <= norm.days[UPD_W-1:0];
			back_s3  <= norm.days < 0;
			tod_s3   <= norm.tod;
			hours_s3 <= hprod[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
		end
		if (en[1]) begin
			days_s4  <= days_s3;
			back_s4  <= back_s3;
			hours_s4 <= hours_s3;
			rem_s4   <= hsub[REM_W-1:0];
		end
		if (en[2]) begin
			days_s5  <= days_s4;
			back_s5  <= back_s4;
			hours_s5 <= hours_s4;
			rem_s5   <= rem_s4;
			mins_s5  <= mprod[MIN_SHIFT+MIN_W-1:MIN_SHIFT];
		end
		if (en[3]) begin
			res_s6.went_back <= back_s5;
			res_s6.days      <= back_s5 ? '0 : days_s5;
			res_s6.hours     <= back_s5 ? '0 : hours_s5;
			res_s6.minutes   <= back_s5 ? '0 : mins_s5;
			res_s6.seconds   <= back_s5 ? '0 : msub[SEC_W-1:0];
		end
	end

endmodule
